[hw/rtl/lfsrf_pkg.sv]
// Shared constants, codes and state type for the longest free slot run finder.
package lfsrf_pkg;

   // Number of minute slots in the bitmap.
   localparam int unsigned SLOTS = 1440;

   // Width of a slot index or slot count. It also holds the slot count itself.
   localparam int unsigned SLOT_W = $clog2(SLOTS + 1);

   localparam int unsigned KIND_W = 2;
   localparam int unsigned REQ_DATA_W = ((2 * SLOT_W + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = ((2 * SLOT_W + 7) / 8) * 8;

   localparam logic [SLOT_W-1:0] SLOT_COUNT = SLOT_W'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_MARK_FREE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK_BUSY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCAN      = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/longest_free_slot_run_finder.sv]
// Top level of the longest free slot run finder: bitmap memory, sequencer and scan unit.

// The block keeps one bit per minute slot of a day (1440 slots) in a single-port
// bitmap memory, every slot busy after reset. Right after reset the block sweeps
// the memory to clear it, one slot per cycle, and holds req_tready low during the
// sweep. A mark transfer (kind 0 for free, kind 1 for busy) writes one slot per
// cycle over the clamped half-open range and occupies the block until the range is
// written; an empty or reversed range, and the unused kind 3, leave the block idle
// and ready. A scan transfer (kind 2) reads every slot through the memory's one
// registered read port, one slot per cycle, and feeds a single run-length counter
// and compare unit; the block then drains the read pipeline and loads the result
// register to raise rsp_tvalid. The block takes one item at a time and is ready
// again once the item's work ends; a finished scan result waits in the output
// register while the next item is accepted, and a later scan holds its result
// until the earlier one has been taken. The scan reports the earliest of the
// longest runs of free slots as a start and an exclusive end, or raises the alarm
// flag with both fields zero when no slot is free. Range fields are clamped to the
// slot count and ignored on a scan.
module longest_free_slot_run_finder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Bits from the lowest up: range_start, range_end, zero fill.
   input  logic [lfsrf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Bits: kind.
   input  logic [lfsrf_pkg::KIND_W-1:0]          req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Bits from the lowest up: free_start, free_end, zero fill.
   output logic [lfsrf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Bits: alarm.
   output logic [0:0]                            rsp_tuser
);
   import lfsrf_pkg::*;

   state_type state_ff, state_in;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] end_ff;
   logic              val_ff;

   // Bitmap memory and its registered read port.
   logic              slot_free_ff [SLOTS];
   logic              rd_data_ff;
   logic              rd_valid_ff;
   logic [SLOT_W-1:0] rd_idx_ff;

   // Scan accumulators.
   logic [SLOT_W-1:0] run_len_ff, run_start_ff;
   logic [SLOT_W-1:0] best_len_ff, best_start_ff;
   logic [SLOT_W-1:0] run_len_next;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_alarm_ff;
   logic [SLOT_W-1:0] rsp_start_ff, rsp_end_ff;

   logic [SLOT_W-1:0] req_start, req_end;
   logic [SLOT_W-1:0] clamp_start, clamp_end;
   logic              req_fire;
   logic              range_ok;

   logic              wr_en;
   logic              wr_val;
   logic              rd_en;
   logic              load_rsp;
   logic              scan_init;

   assign req_start   = req_tdata[SLOT_W-1:0];
   assign req_end     = req_tdata[2*SLOT_W-1:SLOT_W];
   assign clamp_start = (req_start > SLOT_COUNT) ? SLOT_COUNT : req_start;
   assign clamp_end   = (req_end > SLOT_COUNT) ? SLOT_COUNT : req_end;
   assign range_ok    = clamp_start < clamp_end;
   assign req_fire    = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if ((req_tuser == KIND_MARK_FREE || req_tuser == KIND_MARK_BUSY) && range_ok) begin
                  state_in = ST_MARK;
               end else if (req_tuser == KIND_SCAN) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_MARK: begin
            if ((idx_ff + SLOT_W'(1)) == end_ff) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (idx_ff == LAST_SLOT) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      wr_en      = 1'b0;
      wr_val     = 1'b0;
      rd_en      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_MARK: begin
            wr_en  = 1'b1;
            wr_val = val_ff;
         end
         ST_SCAN: begin
            rd_en = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign scan_init = req_fire && (req_tuser == KIND_SCAN);

   // Slot index: start of the range on a mark, zero on a scan, then one step a cycle while writing or reading.
   always_comb begin
      idx_in = idx_ff;
      if (req_fire) begin
         idx_in = (req_tuser == KIND_SCAN) ? '0 : clamp_start;
      end else if (wr_en || rd_en) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= rd_en;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         end_ff <= clamp_end;
         val_ff <= (req_tuser == KIND_MARK_FREE);
      end
   end

   // Bitmap memory: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_free_ff[idx_ff] <= wr_val;
      end
      if (rd_en) begin
         rd_data_ff <= slot_free_ff[idx_ff];
      end
      rd_idx_ff <= idx_ff;
   end

   // Run-length unit: one slot per cycle, a single increment and compare.
   assign run_len_next = run_len_ff + SLOT_W'(1);

   always_ff @(posedge clock) begin
      if (scan_init) begin
         run_len_ff    <= '0;
         run_start_ff  <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
      end else if (rd_valid_ff) begin
         if (rd_data_ff) begin
            run_len_ff <= run_len_next;
            // A strictly longer run replaces the best, so ties keep the earliest.
            if (run_len_next > best_len_ff) begin
               best_len_ff   <= run_len_next;
               best_start_ff <= run_start_ff;
            end
         end else begin
            run_len_ff   <= '0;
            run_start_ff <= rd_idx_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_alarm_ff <= (best_len_ff == '0);
         if (best_len_ff == '0) begin
            rsp_start_ff <= '0;
            rsp_end_ff   <= '0;
         end else begin
            rsp_start_ff <= best_start_ff;
            rsp_end_ff   <= best_start_ff + best_len_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_alarm_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*SLOT_W){1'b0}}, rsp_end_ff, rsp_start_ff};

`ifndef SYNTHESIS
   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("read data arrived outside a scan");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (idx_ff < end_ff && end_ff <= SLOT_COUNT))
      else $error("mark index left its range");

   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |->
         (({1'b0, best_start_ff} + {1'b0, best_len_ff}) <= {1'b0, SLOT_COUNT}))
      else $error("best run extends past the last slot");

   a_best_covers_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (run_len_ff <= best_len_ff))
      else $error("current run longer than best run");

   a_alarm_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_alarm_ff) |-> (rsp_start_ff == '0 && rsp_end_ff == '0))
      else $error("alarm result carries nonzero fields");
`endif

endmodule
